// ===== hdl/pidc_pkg.sv =====
// shared types and constants of the pid controller
package pidc_pkg;

    localparam int ErrW    = 16;
    localparam int DtW     = 16;
    localparam int GainW   = 16;
    localparam int IntegW  = 32;
    localparam int DerivW  = 32;
    localparam int DriveW  = 16;
    localparam int CfgIdxW = 3;
    localparam int CfgDatW = 32;

    // shared multiplier operands and product
    localparam int MulAW = 17;
    localparam int MulBW = 32;
    localparam int ProdW = MulAW + MulBW;

    // integral sum before clamping
    localparam int IsumW = 34;

    // divider: magnitude of (error difference * 4096) fits 28 bits
    localparam int FracBits = 12;
    localparam int DivBits  = 28;
    localparam int DivCntW  = $clog2(DivBits);

    // output accumulator and floor shift
    localparam int AccW      = 62;
    localparam int OutShift  = 20;
    localparam int RawW      = AccW - OutShift;

    typedef enum logic [CfgIdxW-1:0] {
        REG_GAIN_P           = 3'd0,
        REG_GAIN_I           = 3'd1,
        REG_GAIN_D           = 3'd2,
        REG_INTEGRAL_FLOOR   = 3'd3,
        REG_INTEGRAL_CEILING = 3'd4,
        REG_DRIVE_FLOOR      = 3'd5,
        REG_DRIVE_CEILING    = 3'd6
    } pidc_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_ED,
        S_INTEG,
        S_DIV,
        S_MUL_P,
        S_MUL_I,
        S_MUL_D,
        S_ACC_D,
        S_DONE
    } pidc_state_t;

    typedef enum logic [1:0] {
        MUL_ERR_DT,
        MUL_GAIN_P,
        MUL_GAIN_I,
        MUL_GAIN_D
    } pidc_mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD_P,
        ACC_ADD_I,
        ACC_ADD_D
    } pidc_acc_op_t;

    typedef struct packed {
        logic          load_in;
        logic          mul_en;
        pidc_mul_sel_t mul_sel;
        logic          integ_upd;
        logic          div_step;
        logic          deriv_upd;
        pidc_acc_op_t  acc_op;
        logic          load_out;
    } pidc_cmd_t;

    typedef struct packed {
        logic dt_zero;
        logic div_last;
    } pidc_sts_t;

endpackage

// ===== hdl/pidc_if.sv =====
// handshake channels of the pid controller: sample, result and register write

interface pidc_sample_if;
    logic                        valid;
    logic                        ready;
    logic signed [15:0]          error_sample;
    logic        [15:0]          elapsed;

    modport source (output valid, output error_sample, output elapsed, input ready);
    modport sink   (input valid, input error_sample, input elapsed, output ready);
endinterface

interface pidc_result_if;
    logic                        valid;
    logic                        ready;
    logic signed [15:0]          drive;
    logic                        clamped;

    modport source (output valid, output drive, output clamped, input ready);
    modport sink   (input valid, input drive, input clamped, output ready);
endinterface

interface pidc_cfg_if;
    logic                        valid;
    logic                        ready;
    logic        [2:0]           index;
    logic        [31:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/pidc_ctrl.sv =====
// sequencer of the pid step
module pidc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  pidc_pkg::pidc_sts_t sts,
    output pidc_pkg::pidc_cmd_t cmd
);
    import pidc_pkg::*;

    pidc_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '{load_in: 1'b0, mul_en: 1'b0, mul_sel: MUL_ERR_DT,
                       integ_upd: 1'b0, div_step: 1'b0, deriv_upd: 1'b0,
                       acc_op: ACC_HOLD, load_out: 1'b0};
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_MUL_ED;
                end
            end
            S_MUL_ED:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_ERR_DT;
                state_next  = S_INTEG;
            end
            S_INTEG:
            begin
                cmd.integ_upd = 1'b1;
                state_next    = sts.dt_zero ? S_MUL_P : S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_MUL_P;
                end
            end
            S_MUL_P:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_GAIN_P;
                cmd.deriv_upd = !sts.dt_zero;
                state_next    = S_MUL_I;
            end
            S_MUL_I:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_GAIN_I;
                cmd.acc_op  = ACC_LOAD_P;
                state_next  = S_MUL_D;
            end
            S_MUL_D:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_GAIN_D;
                cmd.acc_op  = ACC_ADD_I;
                state_next  = S_ACC_D;
            end
            S_ACC_D:
            begin
                cmd.acc_op = ACC_ADD_D;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_MUL_ED))
        else $error("accepted beat did not start a step");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

    a_div_needs_dt: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> !sts.dt_zero)
        else $error("divider stepped with zero elapsed time");

    a_load_out_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("loaded result not shown as valid");
`endif

endmodule

// ===== hdl/pidc_datapath.sv =====
// registers, shared multiplier, divider and clamps of the pid step
module pidc_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pidc_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [pidc_pkg::CfgDatW-1:0]  cfg_data,
    input  logic signed [pidc_pkg::ErrW-1:0] error_sample,
    input  logic [pidc_pkg::DtW-1:0]      elapsed,
    input  pidc_pkg::pidc_cmd_t           cmd,
    output pidc_pkg::pidc_sts_t           sts,
    output logic signed [pidc_pkg::DriveW-1:0] drive,
    output logic                          clamped
);
    import pidc_pkg::*;

    // configuration
    logic signed [GainW-1:0]  gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [IntegW-1:0] integ_floor_reg, integ_ceiling_reg;
    logic signed [DriveW-1:0] drive_floor_reg, drive_ceiling_reg;

    // persistent state
    logic signed [IntegW-1:0] integral_reg, integral_next;
    logic signed [ErrW-1:0]   prev_err_reg;
    logic signed [DerivW-1:0] deriv_reg, deriv_next;

    // per-step working registers
    logic signed [ErrW-1:0]   err_reg;
    logic        [DtW-1:0]    dt_reg;
    logic signed [ProdW-1:0]  mul_reg;
    logic signed [AccW-1:0]   acc_reg, acc_next;
    logic        [DtW-1:0]    rem_reg, rem_next;
    logic        [DivBits-1:0] quo_reg, quo_next;
    logic        [DivCntW-1:0] div_cnt_reg;
    logic                     neg_reg;
    logic signed [DriveW-1:0] drive_reg;
    logic                     clamped_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg        <= 16'sd256;
            gain_i_reg        <= 16'sd256;
            gain_d_reg        <= 16'sd256;
            integ_floor_reg   <= -32'sd16777216;
            integ_ceiling_reg <= 32'sd16777216;
            drive_floor_reg   <= -16'sd4096;
            drive_ceiling_reg <= 16'sd4096;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAIN_P:           gain_p_reg        <= cfg_data[GainW-1:0];
                REG_GAIN_I:           gain_i_reg        <= cfg_data[GainW-1:0];
                REG_GAIN_D:           gain_d_reg        <= cfg_data[GainW-1:0];
                REG_INTEGRAL_FLOOR:   integ_floor_reg   <= cfg_data[IntegW-1:0];
                REG_INTEGRAL_CEILING: integ_ceiling_reg <= cfg_data[IntegW-1:0];
                REG_DRIVE_FLOOR:      drive_floor_reg   <= cfg_data[DriveW-1:0];
                REG_DRIVE_CEILING:    drive_ceiling_reg <= cfg_data[DriveW-1:0];
                default:              ;
            endcase
        end
    end

    // shared multiplier
    logic signed [MulAW-1:0] mul_a;
    logic signed [MulBW-1:0] mul_b;

    always_comb
    begin
        mul_a = MulAW'(gain_p_reg);
        mul_b = MulBW'(err_reg);
        case (cmd.mul_sel)
            MUL_ERR_DT:
            begin
                mul_a = $signed({1'b0, dt_reg});
                mul_b = MulBW'(err_reg);
            end
            MUL_GAIN_P:
            begin
                mul_a = MulAW'(gain_p_reg);
                mul_b = MulBW'(err_reg);
            end
            MUL_GAIN_I:
            begin
                mul_a = MulAW'(gain_i_reg);
                mul_b = integral_reg;
            end
            MUL_GAIN_D:
            begin
                mul_a = MulAW'(gain_d_reg);
                mul_b = deriv_reg;
            end
            default:
            begin
                mul_a = MulAW'(gain_p_reg);
                mul_b = MulBW'(err_reg);
            end
        endcase
    end

    // integral update, ceiling then floor
    logic signed [IsumW-1:0] isum, isum_hi;

    always_comb
    begin
        isum    = IsumW'(integral_reg) + IsumW'(mul_reg);
        isum_hi = (isum > IsumW'(integ_ceiling_reg)) ? IsumW'(integ_ceiling_reg) : isum;
        if (isum_hi < IsumW'(integ_floor_reg))
        begin
            integral_next = integ_floor_reg;
        end
        else
        begin
            integral_next = isum_hi[IntegW-1:0];
        end
    end

    // derivative dividend: a zero previous error counts as no change
    logic signed [ErrW-1:0] prev_eff;
    logic signed [ErrW:0]   err_diff;
    logic        [ErrW:0]   diff_mag;

    always_comb
    begin
        prev_eff = (prev_err_reg == '0) ? err_reg : prev_err_reg;
        err_diff = (ErrW+1)'(err_reg) - (ErrW+1)'(prev_eff);
        diff_mag = err_diff[ErrW] ? (ErrW+1)'(-err_diff) : err_diff;
    end

    // restoring divider, one quotient bit a cycle
    logic [DtW:0] rem_sh, rem_sub;

    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[DivBits-1]};
        rem_sub = rem_sh - {1'b0, dt_reg};
        if (!rem_sub[DtW])
        begin
            rem_next = rem_sub[DtW-1:0];
            quo_next = {quo_reg[DivBits-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_sh[DtW-1:0];
            quo_next = {quo_reg[DivBits-2:0], 1'b0};
        end
    end

    // quotient stays below 2^28, so it fits the signed 32-bit derivative
    always_comb
    begin
        if (neg_reg)
        begin
            deriv_next = -$signed({{(DerivW-DivBits){1'b0}}, quo_reg});
        end
        else
        begin
            deriv_next = $signed({{(DerivW-DivBits){1'b0}}, quo_reg});
        end
    end

    // accumulator of the three terms
    always_comb
    begin
        acc_next = acc_reg;
        case (cmd.acc_op)
            ACC_LOAD_P: acc_next = AccW'(mul_reg) <<< FracBits;
            ACC_ADD_I:  acc_next = acc_reg + AccW'(mul_reg);
            ACC_ADD_D:  acc_next = acc_reg + (AccW'(mul_reg) <<< FracBits);
            default:    acc_next = acc_reg;
        endcase
    end

    // floor by 2^20, then drive clamp
    logic signed [RawW-1:0] raw, raw_hi, raw_lim;

    always_comb
    begin
        raw     = RawW'(acc_reg >>> OutShift);
        raw_hi  = (raw > RawW'(drive_ceiling_reg)) ? RawW'(drive_ceiling_reg) : raw;
        raw_lim = (raw_hi < RawW'(drive_floor_reg)) ? RawW'(drive_floor_reg) : raw_hi;
    end

    // persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
            prev_err_reg <= '0;
            deriv_reg    <= '0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.integ_upd)
            begin
                integral_reg <= integral_next;
                prev_err_reg <= err_reg;
                div_cnt_reg  <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if (cmd.deriv_upd)
            begin
                deriv_reg <= deriv_next;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            err_reg <= error_sample;
            dt_reg  <= elapsed;
        end
        if (cmd.mul_en)
        begin
            mul_reg <= ProdW'(mul_a) * ProdW'(mul_b);
        end
        if (cmd.integ_upd)
        begin
            rem_reg <= '0;
            quo_reg <= {diff_mag[ErrW-1:0], {FracBits{1'b0}}};
            neg_reg <= err_diff[ErrW];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        acc_reg <= acc_next;
        if (cmd.load_out)
        begin
            drive_reg   <= raw_lim[DriveW-1:0];
            clamped_reg <= (raw_lim != raw);
        end
    end

    assign sts.dt_zero  = (dt_reg == '0);
    assign sts.div_last = (div_cnt_reg == DivCntW'(DivBits - 1));
    assign drive        = drive_reg;
    assign clamped      = clamped_reg;

endmodule

// ===== hdl/pid_with_integrator_and_output_clamp_unit.sv =====
// top level of the single-axis pid controller with integrator and output clamps
// each sample beat carries a signed q3.12 error and the elapsed time in units of
// 2^-12 s; the block keeps a q8.24 integral clamped to its limits, a derivative
// formed as the error change over the elapsed time (held when elapsed is zero)
// and the previous error, and returns one result beat per sample: the q8.8-gain
// weighted sum floored to q3.12, clamped to the drive limits, with a flag set
// when the clamp cut it. one sample is in work at a time: a step runs from acceptance
// to the result register through the bit-serial restoring divider when elapsed is
// nonzero and skips the divider when elapsed is zero; a single 17x32 multiplier is
// shared by the four products. the next sample is taken as soon as the step ends,
// even while the previous result still waits on the result channel. register
// writes are always accepted and must only be issued while no step is in progress;
// writes to an unknown index are dropped
module pid_with_integrator_and_output_clamp_unit (
    input  logic        clk,
    input  logic        rst_n,
    pidc_cfg_if.sink    cfg,
    pidc_sample_if.sink sample,
    pidc_result_if.source result
);
    import pidc_pkg::*;

    pidc_cmd_t cmd;
    pidc_sts_t sts;

    // register writes never stall
    assign cfg.ready = 1'b1;

    // sequencer: owns the sample and result handshakes and the result valid flag
    pidc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath: configuration, state, multiplier, divider, clamps, result payload
    pidc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .error_sample (sample.error_sample),
        .elapsed      (sample.elapsed),
        .cmd          (cmd),
        .sts          (sts),
        .drive        (result.drive),
        .clamped      (result.clamped)
    );

endmodule
